FILE: hdl/lcdfb_pkg.sv
// Shared types and constants for the LCD framebuffer refresh engine.
// No dependencies; imported by the controller, datapath and top level.
package lcdfb_pkg;

    // Request kinds carried on the input tuser
    localparam logic [1:0] OP_SET_PIXEL = 2'd0;
    localparam logic [1:0] OP_START     = 2'd1;
    localparam logic [1:0] OP_PULL      = 2'd2;

    // Panel command bytes
    localparam logic [7:0] CMD_PAGE   = 8'b1011_0000;
    localparam logic [7:0] CMD_COL_HI = 8'b0001_0000;
    localparam logic [7:0] CMD_COL_LO = 8'b0000_0000;
    localparam logic [7:0] NIBBLE     = 8'h0f;

    // Refresh sequence phases
    localparam logic [1:0] PH_PAGE   = 2'd0;
    localparam logic [1:0] PH_COL_HI = 2'd1;
    localparam logic [1:0] PH_COL_LO = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    // Column compares: area_x_end is 8 bits, panel width at most 256
    localparam int XCMP_W = 9;
    // Page compares: page fields at most 3 bits, page count at most 8
    localparam int PCMP_W = 4;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_MODIFY = 4'b0100,
        ST_PUSH   = 4'b1000
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic modify_wr;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic rmw_needed;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hdl/lcd_framebuffer_refresh_engine.sv
// Top level of the LCD framebuffer refresh engine.
// Depends on lcdfb_pkg, lcdfb_ctrl and lcdfb_datapath.
//
// Page-organized monochrome framebuffer with a page-addressed panel feeder.
// Input stream: s_tuser selects the request (set pixel, start refresh, pull
// byte); s_tdata carries the pixel and area fields. Every accepted request
// gives exactly one result on the output stream: m_tdata holds the byte and
// its flags, m_tuser marks display data versus command, m_tlast marks the
// point where chip select rises after the byte.
// Sequencing: a request is taken in ST_IDLE and its result is loaded into
// the output register from ST_PUSH once that register is free. A set-pixel
// request on the panel passes through ST_MODIFY on the way: the frame
// memory has one read and one write port, so the read-modify-write of the
// pixel byte adds a state. One request is in flight at a time.
// Reset: the frame memory is swept to zero, one byte a cycle, over all
// PAGE_COUNT * PANEL_WIDTH entries (512 at the default size); s_tready stays
// low during the sweep.
// Stall: a result waits in the output register while m_tready is low; the
// next request can still be taken, and its result waits behind it.
module lcd_framebuffer_refresh_engine
    import lcdfb_pkg::*;
#(
    parameter int PANEL_WIDTH = 128,
    parameter int PAGE_COUNT  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_x[6:0], pixel_y[11:7], pixel_value[12], area_x_start[19:13],
    // area_x_end[27:20], area_y_start[33:28], area_y_end[39:34]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op[1:0]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // byte_valid[0], out_byte[8:1], refresh_done[9], busy_res[10],
    // start_rejected[11], zero fill[15:12]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // frame_end
    output logic                  m_tlast,
    // is_data
    output logic                  m_tuser
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lcdfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcdfb_datapath #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PAGE_COUNT  (PAGE_COUNT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: hdl/lcdfb_ctrl.sv
// Controller state machine of the LCD framebuffer refresh engine.
// Depends on lcdfb_pkg; drives the datapath through dp_cmd_t.
module lcdfb_ctrl
    import lcdfb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // Sequence clear pass, accept, read-modify-write and result load
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.rmw_needed ? ST_MODIFY : ST_PUSH;
                end
            end
            ST_MODIFY:
            begin
                cmd.modify_wr = 1'b1;
                state_next    = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

FILE: hdl/lcdfb_datapath.sv
// Datapath of the LCD framebuffer refresh engine: frame memory, refresh
// counters and the output register. Depends on lcdfb_pkg.
module lcdfb_datapath
    import lcdfb_pkg::*;
#(
    parameter int PANEL_WIDTH = 128,
    parameter int PAGE_COUNT  = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    localparam int DEPTH = PAGE_COUNT * PANEL_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(PANEL_WIDTH + 1);
    localparam int PGW   = $clog2(PAGE_COUNT + 1);

    // Input fields
    logic [6:0] pixel_x;
    logic [4:0] pixel_y;
    logic       pixel_value;
    logic [6:0] area_x_start;
    logic [7:0] area_x_end;
    logic [5:0] area_y_start;
    logic [5:0] area_y_end;

    assign pixel_x      = s_tdata[6:0];
    assign pixel_y      = s_tdata[11:7];
    assign pixel_value  = s_tdata[12];
    assign area_x_start = s_tdata[19:13];
    assign area_x_end   = s_tdata[27:20];
    assign area_y_start = s_tdata[33:28];
    assign area_y_end   = s_tdata[39:34];

    // Refresh state
    logic           active_reg, active_next;
    logic [1:0]     phase_reg, phase_next;
    logic [PGW-1:0] page_reg, page_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [6:0]     xs_reg, xs_next;
    logic [CW-1:0]  xe_reg, xe_next;
    logic [PGW-1:0] pe_reg, pe_next;

    // Clear pass and memory
    logic [AW-1:0] clr_addr_reg;
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          mem_re;
    logic [AW-1:0] rd_addr;

    // Pending pixel write
    logic [AW-1:0] pix_addr_reg;
    logic [2:0]    pix_bit_reg;
    logic          pix_val_reg;
    logic [7:0]    pix_mask;

    // Pending result
    logic       res_valid_reg, res_valid_next;
    logic [7:0] res_byte_reg, res_byte_next;
    logic       res_data_reg, res_data_next;
    logic       res_fend_reg, res_fend_next;
    logic       res_done_reg, res_done_next;
    logic       res_rej_reg, res_rej_next;
    logic       res_busy_reg;

    // Output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_bvalid_reg;
    logic       out_data_reg;
    logic       out_fend_reg;
    logic       out_done_reg;
    logic       out_busy_reg;
    logic       out_rej_reg;
    logic       out_free;

    // Decode helpers
    logic               op_set;
    logic               op_start;
    logic               op_pull;
    logic [1:0]         pix_page;
    logic               pix_hit;
    logic [AW-1:0]      pix_addr;
    logic [XCMP_W-1:0]  xe_clamp;
    logic [PCMP_W-1:0]  ps_ext;
    logic [PCMP_W-1:0]  pe_ext;
    logic [PCMP_W-1:0]  pe_clamp;
    logic               area_empty;
    logic [AW-1:0]      pull_addr;
    logic [CW-1:0]      col_inc;
    logic [PGW-1:0]     page_inc;
    logic               pull_read;

    assign op_set   = (s_tuser == OP_SET_PIXEL);
    assign op_start = (s_tuser == OP_START);
    assign op_pull  = (s_tuser == OP_PULL);

    // Locate the pixel byte and check it lies on the panel
    assign pix_page = pixel_y[4:3];
    assign pix_hit  = ({2'b00, pixel_x} < XCMP_W'(PANEL_WIDTH))
                   && ({2'b00, pix_page} < PCMP_W'(PAGE_COUNT));
    assign pix_addr = AW'(32'(pix_page) * PANEL_WIDTH + 32'(pixel_x));

    // Clamp the requested area to the panel
    assign xe_clamp = ({1'b0, area_x_end} > XCMP_W'(PANEL_WIDTH))
                    ? XCMP_W'(PANEL_WIDTH) : {1'b0, area_x_end};
    assign ps_ext   = {1'b0, area_y_start[5:3]};
    assign pe_ext   = {1'b0, area_y_end[5:3]};
    assign pe_clamp = (pe_ext > PCMP_W'(PAGE_COUNT)) ? PCMP_W'(PAGE_COUNT) : pe_ext;
    assign area_empty = ({2'b00, area_x_start} >= xe_clamp) || (ps_ext >= pe_clamp);

    assign pull_addr = AW'(32'(page_reg) * PANEL_WIDTH + 32'(col_reg));
    assign col_inc   = col_reg + CW'(1);
    assign page_inc  = page_reg + PGW'(1);
    assign pull_read = op_pull && active_reg && (phase_reg == PH_DATA);

    // Advance refresh state and form the result of the accepted request
    always_comb
    begin
        active_next    = active_reg;
        phase_next     = phase_reg;
        page_next      = page_reg;
        col_next       = col_reg;
        xs_next        = xs_reg;
        xe_next        = xe_reg;
        pe_next        = pe_reg;
        res_valid_next = 1'b0;
        res_byte_next  = '0;
        res_data_next  = 1'b0;
        res_fend_next  = 1'b0;
        res_done_next  = 1'b0;
        res_rej_next   = 1'b0;
        if (op_start)
        begin
            if (active_reg)
            begin
                res_rej_next = 1'b1;
            end
            else if (!area_empty)
            begin
                xs_next     = area_x_start;
                xe_next     = CW'(xe_clamp);
                pe_next     = PGW'(pe_clamp);
                page_next   = PGW'(ps_ext);
                col_next    = CW'(area_x_start);
                phase_next  = PH_PAGE;
                active_next = 1'b1;
            end
        end
        else if (op_pull && active_reg)
        begin
            res_valid_next = 1'b1;
            case (phase_reg)
                PH_PAGE:
                begin
                    res_byte_next = CMD_PAGE | ({4'b0000, 4'(page_reg)} & NIBBLE);
                    res_fend_next = 1'b1;
                    phase_next    = PH_COL_HI;
                end
                PH_COL_HI:
                begin
                    res_byte_next = CMD_COL_HI | {5'b00000, xs_reg[6:4]};
                    res_fend_next = 1'b1;
                    phase_next    = PH_COL_LO;
                end
                PH_COL_LO:
                begin
                    res_byte_next = CMD_COL_LO | {4'b0000, xs_reg[3:0]};
                    res_fend_next = 1'b1;
                    phase_next    = PH_DATA;
                end
                default:
                begin
                    res_data_next = 1'b1;
                    col_next      = col_inc;
                    if (col_inc >= xe_reg)
                    begin
                        res_fend_next = 1'b1;
                        col_next      = CW'(xs_reg);
                        page_next     = page_inc;
                        phase_next    = PH_PAGE;
                        if (page_inc >= pe_reg)
                        begin
                            active_next   = 1'b0;
                            res_done_next = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= PH_PAGE;
            page_reg   <= '0;
            col_reg    <= '0;
            xs_reg     <= '0;
            xe_reg     <= '0;
            pe_reg     <= '0;
        end
        else if (cmd.accept)
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            page_reg   <= page_next;
            col_reg    <= col_next;
            xs_reg     <= xs_next;
            xe_reg     <= xe_next;
            pe_reg     <= pe_next;
        end
    end

    // Hold the result and the pending pixel write until loaded
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_valid_reg <= res_valid_next;
            res_byte_reg  <= res_byte_next;
            res_data_reg  <= res_data_next;
            res_fend_reg  <= res_fend_next;
            res_done_reg  <= res_done_next;
            res_rej_reg   <= res_rej_next;
            res_busy_reg  <= active_next;
            pix_addr_reg  <= pix_addr;
            pix_bit_reg   <= pixel_y[2:0];
            pix_val_reg   <= pixel_value;
        end
    end

    // Step the clear pass through every memory entry after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Memory port selection
    assign pix_mask = 8'b0000_0001 << pix_bit_reg;
    assign mem_we   = cmd.clear_wr || cmd.modify_wr;
    assign wr_addr  = cmd.clear_wr ? clr_addr_reg : pix_addr_reg;
    assign wr_data  = cmd.clear_wr ? 8'h00
                    : ((rd_data_reg & ~pix_mask) | (pix_val_reg ? pix_mask : 8'h00));
    assign mem_re   = cmd.accept && ((op_set && pix_hit) || pull_read);
    assign rd_addr  = op_set ? pix_addr : pull_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Output register: load when empty or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tvalid && status.out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_byte_reg   <= res_data_reg ? rd_data_reg : res_byte_reg;
            out_bvalid_reg <= res_valid_reg;
            out_data_reg   <= res_data_reg;
            out_fend_reg   <= res_fend_reg;
            out_done_reg   <= res_done_reg;
            out_busy_reg   <= res_busy_reg;
            out_rej_reg    <= res_rej_reg;
        end
    end

    // Status back to the controller
    assign out_free = !out_valid_reg || m_tready;

    assign status.clear_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign status.rmw_needed = op_set && pix_hit;
    assign status.out_free   = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_rej_reg, out_busy_reg, out_done_reg,
                       out_byte_reg, out_bvalid_reg};
    assign m_tlast  = out_fend_reg;
    assign m_tuser  = out_data_reg;

endmodule

FILE: hdl/lcdfb_checker.sv
// Port-level checker for the LCD framebuffer refresh engine, bound to the
// top level. Depends on lcdfb_pkg for stream widths.
module lcdfb_checker
    import lcdfb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output result dropped while stalled");

    // A result without a byte carries nothing else but busy and reject
    a_no_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == 8'h00) && !m_tuser && !m_tlast
                                    && !m_tdata[9])
        else $error("result without a byte carries byte fields");

    // The last byte of a refresh ends a frame and leaves the engine idle
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> m_tlast && m_tuser && !m_tdata[10])
        else $error("refresh end without frame end or while still busy");

    // A start is only rejected while a refresh runs
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tdata[10] && !m_tdata[0])
        else $error("start rejected while idle");

endmodule

bind lcd_framebuffer_refresh_engine lcdfb_checker u_lcdfb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/tb_lcd_framebuffer_refresh_engine.sv
// Self-checking testbench for lcd_framebuffer_refresh_engine: a shadow framebuffer and
// refresh sequencer predict every result byte, which is compared as it leaves the block.
// Depends on lcdfb_pkg and the engine RTL only.
module tb_lcd_framebuffer_refresh_engine;
    import lcdfb_pkg::*;

    localparam int PANEL_WIDTH    = 128;
    localparam int PAGE_COUNT     = 4;
    localparam int FRAME_BYTES    = PANEL_WIDTH * PAGE_COUNT;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int RANDOM_ITEMS   = 960;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES    = 10;
    // Cycles with no request or result moving; covers the reset sweep and the long hold
    localparam int WATCHDOG_LIMIT = 5000;

    // One result from the panel stream, split into its fields
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic       is_data;
        logic       frame_end;
        logic       refresh_done;
        logic       busy;
        logic       rejected;
    } panel_byte_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // Shadow of the engine state
    logic [7:0] shadow_frame [FRAME_BYTES];
    logic       refresh_on  = 1'b0;
    logic [1:0] seq_phase   = PH_PAGE;
    logic [3:0] cur_page    = '0;
    logic [8:0] cur_col     = '0;
    logic [6:0] lat_x_start = '0;
    logic [8:0] lat_x_end   = '0;
    logic [3:0] lat_page_end = '0;

    panel_byte_t expected_bytes [$];
    int          error_count  = 0;
    int          burst_left   = 0;
    int          stall_cycles = 0;
    logic        hold_rx      = 1'b0;

    lcd_framebuffer_refresh_engine #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .PAGE_COUNT  (PAGE_COUNT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
            shadow_frame[i] = 8'h00;
    end

    // Work out the result of one accepted request and advance the shadow state
    function automatic panel_byte_t predict_panel_byte(input logic [1:0] op,
                                                       input logic [IN_DATA_W-1:0] d);
        panel_byte_t r;
        logic [6:0]  px;
        logic [4:0]  py;
        logic [6:0]  xs;
        logic [8:0]  xe;
        logic [3:0]  ps;
        logic [3:0]  pe;
        int          idx;
        r  = '0;
        px = d[6:0];
        py = d[11:7];
        xs = d[19:13];
        xe = {1'b0, d[27:20]};
        ps = {1'b0, d[33:31]};
        pe = {1'b0, d[39:37]};
        case (op)
            OP_SET_PIXEL:
            begin
                if (px < PANEL_WIDTH && py[4:3] < PAGE_COUNT)
                begin
                    idx = py[4:3] * PANEL_WIDTH + px;
                    shadow_frame[idx][py[2:0]] = d[12];
                end
            end
            OP_START:
            begin
                if (refresh_on)
                    r.rejected = 1'b1;
                else
                begin
                    // Clamp the area to the panel, then drop it if empty
                    if (xe > PANEL_WIDTH)
                        xe = 9'(PANEL_WIDTH);
                    if (pe > PAGE_COUNT)
                        pe = 4'(PAGE_COUNT);
                    if (xs < xe && ps < pe)
                    begin
                        lat_x_start  = xs;
                        lat_x_end    = xe;
                        lat_page_end = pe;
                        cur_page     = ps;
                        cur_col      = {2'b00, xs};
                        seq_phase    = PH_PAGE;
                        refresh_on   = 1'b1;
                    end
                end
            end
            OP_PULL:
            begin
                if (refresh_on)
                begin
                    r.byte_valid = 1'b1;
                    case (seq_phase)
                        PH_PAGE:
                        begin
                            r.out_byte  = CMD_PAGE | ({4'b0, cur_page} & NIBBLE);
                            r.frame_end = 1'b1;
                            seq_phase   = PH_COL_HI;
                        end
                        PH_COL_HI:
                        begin
                            r.out_byte  = CMD_COL_HI | ({1'b0, lat_x_start} >> 4);
                            r.frame_end = 1'b1;
                            seq_phase   = PH_COL_LO;
                        end
                        PH_COL_LO:
                        begin
                            r.out_byte  = CMD_COL_LO | ({1'b0, lat_x_start} & NIBBLE);
                            r.frame_end = 1'b1;
                            seq_phase   = PH_DATA;
                        end
                        default:
                        begin
                            idx        = cur_page * PANEL_WIDTH + cur_col;
                            r.out_byte = (idx < FRAME_BYTES) ? shadow_frame[idx] : 8'h00;
                            r.is_data  = 1'b1;
                            cur_col    = cur_col + 1'b1;
                            // Wrap to the next page once the column range is done
                            if (cur_col >= lat_x_end)
                            begin
                                r.frame_end = 1'b1;
                                cur_col     = {2'b00, lat_x_start};
                                cur_page    = cur_page + 1'b1;
                                seq_phase   = PH_PAGE;
                                if (cur_page >= lat_page_end)
                                begin
                                    refresh_on     = 1'b0;
                                    r.refresh_done = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.busy = refresh_on;
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_request(
        input logic [6:0] px, input logic [4:0] py, input logic pv,
        input logic [6:0] xs, input logic [7:0] xe,
        input logic [5:0] ys, input logic [5:0] ye);
        return {ye, ys, xe, xs, pv, py, px};
    endfunction

    // Offer one request, hold it until taken, then record its expected result.
    // The sender runs in bursts; a gap follows the end of each burst.
    task automatic send_request(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        expected_bytes.push_back(predict_panel_byte(op, d));
        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 30);
        end
    endtask

    task automatic set_pixel_req(input int x, input int y, input int v);
        send_request(OP_SET_PIXEL,
                     pack_request(7'(x), 5'(y), 1'(v), 7'($urandom), 8'($urandom),
                                  6'($urandom), 6'($urandom)));
    endtask

    task automatic start_req(input int xs, input int xe, input int ys, input int ye);
        send_request(OP_START,
                     pack_request(7'($urandom), 5'($urandom), 1'($urandom),
                                  7'(xs), 8'(xe), 6'(ys), 6'(ye)));
    endtask

    task automatic pull_req();
        send_request(OP_PULL, IN_DATA_W'({$urandom, $urandom}));
    endtask

    task automatic nop_req();
        send_request(OP_NOP, IN_DATA_W'({$urandom, $urandom}));
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endtask

    // Pull while idle, the unused op code, and starts whose area is empty
    task automatic test_idle_requests();
        pull_req();
        nop_req();
        start_req(127, 127, 0, 32);
        start_req(100, 0, 0, 32);
        start_req(0, 128, 16, 15);
        start_req(0, 255, 32, 63);
    endtask

    // Write the panel corners, then clear one again
    task automatic test_pixel_corners();
        set_pixel_req(0, 0, 1);
        set_pixel_req(127, 31, 1);
        set_pixel_req(127, 0, 1);
        set_pixel_req(0, 31, 1);
        set_pixel_req(120, 24, 1);
        set_pixel_req(0, 0, 0);
    endtask

    // Clamped area at the bottom right, a start while busy, a pixel written mid-refresh
    task automatic test_clamped_refresh();
        start_req(120, 255, 24, 63);
        pull_req();
        start_req(0, 8, 0, 8);
        pull_req();
        pull_req();
        pull_req();
        set_pixel_req(125, 30, 1);
        while (refresh_on)
            pull_req();
        pull_req();
    endtask

    // Hold the receiver off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_rx = 1'b1;
        start_req(0, 6, 0, 16);
        while (refresh_on)
            pull_req();
        set_pixel_req(3, 9, 1);
    endtask

    // Mostly well-formed scribble/start/pull sequences, with noise mixed in
    task automatic test_random_traffic();
        int sent;
        int ps;
        int pe;
        int xs;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            repeat ($urandom_range(0, 10))
            begin
                set_pixel_req($urandom, $urandom, $urandom);
                sent++;
            end
            ps = $urandom_range(0, 3);
            case ($urandom_range(0, 19))
                0, 1:
                    start_req($urandom, $urandom, $urandom, $urandom);
                2:
                    start_req($urandom_range(0, 3), $urandom_range(128, 255),
                              ps * 8 + $urandom_range(0, 7),
                              (ps == 3) ? $urandom_range(32, 63)
                                        : (ps + 1) * 8 + $urandom_range(0, 7));
                default:
                begin
                    xs = $urandom_range(0, 127);
                    pe = ps + $urandom_range(1, 2);
                    start_req(xs, xs + $urandom_range(1, 16),
                              ps * 8 + $urandom_range(0, 7),
                              (pe >= PAGE_COUNT) ? $urandom_range(32, 63)
                                                 : pe * 8 + $urandom_range(0, 7));
                end
            endcase
            sent++;
            while (refresh_on)
            begin
                case ($urandom_range(0, 19))
                    0:       set_pixel_req($urandom, $urandom, $urandom);
                    1:       start_req($urandom, $urandom, $urandom, $urandom);
                    2:       nop_req();
                    default: pull_req();
                endcase
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    pull_req();
                else
                    nop_req();
                sent++;
            end
        end
    endtask

    // Reset once, run the tests, drain and report
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_requests();
        test_pixel_corners();
        test_clamped_refresh();
        test_output_backpressure();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: switch stall style at random times; honor a long hold on demand
    initial
    begin
        int style;
        int tick;
        tick = 0;
        forever
        begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(8, 80))
            begin
                @(posedge clk);
                tick++;
                if (hold_rx)
                begin
                    m_tready <= 1'b0;
                    repeat (RX_HOLD_CYCLES) @(posedge clk);
                    hold_rx = 1'b0;
                end
                else
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= $urandom_range(0, 1);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= tick[2];
                    endcase
                end
            end
        end
    end

    // Compare each result leaving the block with the oldest expectation
    always @(posedge clk)
    begin
        panel_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("result 0x%0h arrived with no request pending", m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                check_field("byte_valid", want.byte_valid, m_tdata[0]);
                check_field("out_byte", want.out_byte, m_tdata[8:1]);
                check_field("refresh_done", want.refresh_done, m_tdata[9]);
                check_field("busy_res", want.busy, m_tdata[10]);
                check_field("start_rejected", want.rejected, m_tdata[11]);
                check_field("frame_end", want.frame_end, m_tlast);
                check_field("is_data", want.is_data, m_tuser);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
